### design/row_delete_bitmap_range_engine_macros.svh
// assertion macros shared by the checker
`ifndef ROW_DELETE_BITMAP_RANGE_ENGINE_MACROS_SVH
`define ROW_DELETE_BITMAP_RANGE_ENGINE_MACROS_SVH

// same-cycle implication, disabled in reset
`define RDBRE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdbre: same-cycle check failed");

// next-cycle implication, disabled in reset
`define RDBRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdbre: next-cycle check failed");

`endif

### design/rdbre_pkg.sv
// ----------------------------------------------------------------------------
// rdbre_pkg
// Constants, widths and request codes of the row delete bitmap range engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rdbre_pkg;

    // number of rows held; WORD_BITS is a power of two from 8 to 64
    localparam int ROW_CAPACITY = 4096;
    localparam int WORD_BITS    = 64;

    localparam int NUM_WORDS = (ROW_CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int WORD_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int ROW_W     = $clog2(ROW_CAPACITY);

    // fixed widths of the request fields
    localparam int REQ_W    = 2;
    localparam int ROW_IN_W = 13;
    localparam int CHK_W    = ((ROW_IN_W > ROW_W) ? ROW_IN_W : ROW_W) + 1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_SET   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TEST  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_READ   = 3'b010,
        ST_MODIFY = 3'b100
    } state_t;

endpackage

`default_nettype wire

### design/row_delete_bitmap_range_engine.sv
// a bad range or unused request answers in the cycle after start;
// otherwise the walk visits each bitmap word touched (read, then modify/write)
// throughput: one request at a time, busy while the word walk runs
// reset: every row reads valid; per-word valid flops clear at once, no sweep
// ----------------------------------------------------------------------------
// row_delete_bitmap_range_engine
// Per-row delete bitmap with range set, range clear and range test,
// walking one bitmap word at a time through a read-modify-write memory.
// ----------------------------------------------------------------------------
`default_nettype none

module row_delete_bitmap_range_engine (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [rdbre_pkg::REQ_W-1:0]    req_type,
    input  wire logic [rdbre_pkg::ROW_IN_W-1:0] base_row,
    input  wire logic [rdbre_pkg::ROW_IN_W-1:0] row_count,
    output logic                                done,
    output logic                                all_deleted,
    output logic                                range_error
);

    import rdbre_pkg::*;

    localparam logic [WORD_BITS-1:0] ONES    = {WORD_BITS{1'b1}};
    localparam logic [BIT_W-1:0]     TOP_BIT = BIT_W'(WORD_BITS - 1);

    state_t                   state_reg, state_next;
    logic [REQ_W-1:0]         op_reg, op_next;
    logic [WORD_W-1:0]        word_reg, word_next;
    logic [WORD_W-1:0]        wlo_reg, wlo_next;
    logic [WORD_W-1:0]        whi_reg, whi_next;
    logic [BIT_W-1:0]         lo_bit_reg, lo_bit_next;
    logic [BIT_W-1:0]         hi_bit_reg, hi_bit_next;
    logic                     done_reg, done_next;
    logic                     all_reg, all_next;
    logic                     err_reg, err_next;

    logic [WORD_BITS-1:0]     mem [NUM_WORDS];
    logic [NUM_WORDS-1:0]     valid_reg;
    logic [WORD_BITS-1:0]     rd_data_reg;
    logic                     rd_valid_reg;

    logic                     accept;
    logic [CHK_W-1:0]         end_sum;
    logic                     bad_range;
    logic [ROW_W-1:0]         first_row;
    logic [ROW_W-1:0]         last_row;
    logic [BIT_W-1:0]         lo_bit;
    logic [BIT_W-1:0]         hi_bit;
    logic [WORD_BITS-1:0]     mask;
    logic [WORD_BITS-1:0]     cur_word;
    logic [WORD_BITS-1:0]     new_word;
    logic                     mem_we;
    logic                     test_fail;
    logic                     last_word;

    assign accept = start && (state_reg == ST_IDLE);

    // one past the last row, 1-based start folded in
    assign end_sum   = CHK_W'(base_row) - CHK_W'(1) + CHK_W'(row_count);
    assign bad_range = (base_row == '0) || (row_count == '0) ||
                       (end_sum > CHK_W'(ROW_CAPACITY));
    assign first_row = ROW_W'(CHK_W'(base_row) - CHK_W'(1));
    assign last_row  = ROW_W'(end_sum - CHK_W'(1));

    // partial first and last words get a masked span
    assign lo_bit   = (word_reg == wlo_reg) ? lo_bit_reg : '0;
    assign hi_bit   = (word_reg == whi_reg) ? hi_bit_reg : TOP_BIT;
    assign mask     = (ONES << lo_bit) & (ONES >> (TOP_BIT - hi_bit));
    assign cur_word = rd_valid_reg ? rd_data_reg : '0;
    assign new_word = (op_reg == REQ_SET) ? (cur_word | mask) : (cur_word & ~mask);

    assign mem_we    = (state_reg == ST_MODIFY) && (op_reg != REQ_TEST);
    assign test_fail = (op_reg == REQ_TEST) && ((cur_word & mask) != mask);
    assign last_word = (word_reg == whi_reg);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        word_next   = word_reg;
        wlo_next    = wlo_reg;
        whi_next    = whi_reg;
        lo_bit_next = lo_bit_reg;
        hi_bit_next = hi_bit_reg;
        done_next   = 1'b0;
        all_next    = all_reg;
        err_next    = err_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = req_type;
                    wlo_next    = WORD_W'(first_row >> BIT_W);
                    whi_next    = WORD_W'(last_row >> BIT_W);
                    word_next   = WORD_W'(first_row >> BIT_W);
                    lo_bit_next = first_row[BIT_W-1:0];
                    hi_bit_next = last_row[BIT_W-1:0];
                    if (bad_range || !(req_type inside {REQ_SET, REQ_CLEAR, REQ_TEST}))
                    begin
                        done_next = 1'b1;
                        all_next  = 1'b0;
                        err_next  = bad_range;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                if (test_fail || last_word)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    all_next   = (op_reg == REQ_TEST) && !test_fail;
                    err_next   = 1'b0;
                end
                else
                begin
                    state_next = ST_READ;
                    word_next  = word_reg + WORD_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        word_reg   <= word_next;
        wlo_reg    <= wlo_next;
        whi_reg    <= whi_next;
        lo_bit_reg <= lo_bit_next;
        hi_bit_reg <= hi_bit_next;
        all_reg    <= all_next;
        err_reg    <= err_next;
    end

    // bitmap words; a word never written reads as all valid
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[word_reg] <= new_word;
        end
        if (state_reg == ST_READ)
        begin
            rd_data_reg <= mem[word_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                valid_reg[word_reg] <= 1'b1;
            end
            if (state_reg == ST_READ)
            begin
                rd_valid_reg <= valid_reg[word_reg];
            end
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign all_deleted = all_reg;
    assign range_error = err_reg;

endmodule

`default_nettype wire

### design/rdbre_checker.sv
// ----------------------------------------------------------------------------
// rdbre_checker
// Port-level checks of the row delete bitmap range engine, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "row_delete_bitmap_range_engine_macros.svh"

module rdbre_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           start,
    input wire logic                           busy,
    input wire logic [rdbre_pkg::ROW_IN_W-1:0] base_row,
    input wire logic [rdbre_pkg::ROW_IN_W-1:0] row_count,
    input wire logic                           done,
    input wire logic                           all_deleted,
    input wire logic                           range_error
);

    import rdbre_pkg::*;

    logic zero_start_beat;
    logic zero_count_beat;

    assign zero_start_beat = start && !busy && (base_row == '0);
    assign zero_count_beat = start && !busy && (row_count == '0);

    // an accepted beat either answers next cycle or keeps the engine busy
    `RDBRE_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy)

    // the engine only leaves busy by delivering a result
    `RDBRE_ASSERT_NOW(a_busy_ends_done, $fell(busy), done)

    // a flagged range never reports a passing test
    `RDBRE_ASSERT_NOW(a_err_not_all, done && range_error, !all_deleted)

    // zero start or zero count is flagged on the very next cycle
    `RDBRE_ASSERT_NEXT(a_zero_flagged, zero_start_beat || zero_count_beat,
                       done && range_error && !busy)

endmodule

bind row_delete_bitmap_range_engine rdbre_checker u_rdbre_checker (.*);

`default_nettype wire
